@@ hdl/bb3_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants for the 3x3 box blur: word layouts, control
// flags handed down the pipeline, register indexes and divide constants.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int CNT_W     = 11;              // frame counters and config regs
    localparam int CNT_MAX   = 2**CNT_W - 1;
    localparam int ITEMS_W   = CNT_W + 1;       // holds width + 1
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int SUM_W     = 12;              // nine 8-bit values
    localparam int PROD_W    = 2 * SUM_W;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CNT_W-1:0] MIN_DIM   = 11'd2;
    localparam logic [CNT_W-1:0] DIM_RESET = 11'd1024;

    // floor(s / 9) == (s * 3641) >> 15 for every s below 32768
    localparam logic [SUM_W-1:0] DIV_RECIP = 12'd3641;
    localparam int               DIV_SHIFT = 15;

    localparam logic [CH_W-1:0] ALPHA = 8'hFF;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic            drain;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        frame_last;
    } out_item_t;

    // one window column: row above, centre row, row below
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    // per-word flags from the position counters
    typedef struct packed {
        logic emit;
        logic last;
        logic use_top;
        logic use_bot;
        logic use_left;
        logic use_right;
    } ctl_t;

endpackage
`default_nettype wire

@@ hdl/bb3_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bb3_ram
    import bb3_pkg::*;
#(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = DEF_MAX_WIDTH
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/bb3_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_cell
// One column of the 3x3 window; takes its neighbor's column on every word.
// ----------------------------------------------------------------------------
module bb3_cell
    import bb3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic shift_en,
    input  wire col_t col_in,
    output col_t      col_out
);

    col_t col_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule
`default_nettype wire

@@ hdl/bb3_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_ctrl
// Config registers and frame position counters. Gives each accepted word its
// line store address, a blank flag and its output's emit, last and edge masks.
// ----------------------------------------------------------------------------
module bb3_ctrl
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CNT_W-1:0]             cfg_data,
    input  wire logic                         step,
    input  wire logic                         drain,
    output logic      [$clog2(MAX_WIDTH)-1:0] addr,
    output logic                              blank,
    output ctl_t                              ctl
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int W_LIM = (MAX_WIDTH > CNT_MAX) ? CNT_MAX : MAX_WIDTH;
    localparam int H_LIM = (MAX_HEIGHT > CNT_MAX) ? CNT_MAX : MAX_HEIGHT;
    localparam logic [CNT_W-1:0] W_CAP = CNT_W'(W_LIM);
    localparam logic [CNT_W-1:0] H_CAP = CNT_W'(H_LIM);
    localparam logic [CNT_W-1:0] W_RST = (DIM_RESET > W_CAP) ? W_CAP : DIM_RESET;
    localparam logic [CNT_W-1:0] H_RST = (DIM_RESET > H_CAP) ? H_CAP : DIM_RESET;

    logic [CNT_W-1:0]   width_reg,   width_next;
    logic [CNT_W-1:0]   height_reg,  height_next;
    logic [CNT_W-1:0]   in_col_reg,  in_col_next;
    logic [CNT_W-1:0]   in_row_reg,  in_row_next;
    logic [CNT_W-1:0]   out_col_reg, out_col_next;
    logic [CNT_W-1:0]   out_row_reg, out_row_next;
    logic [ITEMS_W-1:0] items_reg,   items_next;

    logic [CNT_W-1:0]   w_clamp, h_clamp;
    logic [CNT_W-1:0]   ic, row_eff;
    logic [ITEMS_W-1:0] w_ext, h_ext, w_plus1, oc1, or1;
    logic               col_wrap, emit, last;

    // registers hold the clamped value, which is all the counters ever see
    always_comb begin
        if (cfg_data < MIN_DIM) begin
            w_clamp = MIN_DIM;
            h_clamp = MIN_DIM;
        end else begin
            w_clamp = (cfg_data > W_CAP) ? W_CAP : cfg_data;
            h_clamp = (cfg_data > H_CAP) ? H_CAP : cfg_data;
        end
    end

    always_comb begin
        w_ext    = {1'b0, width_reg};
        h_ext    = {1'b0, height_reg};
        w_plus1  = w_ext + 1'b1;
        oc1      = {1'b0, out_col_reg} + 1'b1;
        or1      = {1'b0, out_row_reg} + 1'b1;
        col_wrap = in_col_reg >= width_reg;
        ic       = col_wrap ? '0 : in_col_reg;
        row_eff  = col_wrap ? in_row_reg + 1'b1 : in_row_reg;
        emit     = items_reg >= w_plus1;
        last     = emit && (or1 >= h_ext) && (oc1 >= w_ext);

        blank         = drain || (row_eff >= height_reg);
        addr          = AW'(ic);
        ctl.emit      = emit;
        ctl.last      = last;
        ctl.use_top   = out_row_reg != '0;
        ctl.use_bot   = or1 < h_ext;
        ctl.use_left  = out_col_reg != '0;
        // at column zero the output is the previous row's last pixel
        ctl.use_right = (oc1 < w_ext) && (ic != '0);
    end

    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        items_next   = items_reg;

        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_next  = w_clamp;
                REG_HEIGHT: height_next = h_clamp;
                default:    ;
            endcase
        end

        if (step) begin
            in_col_next = ic + 1'b1;
            in_row_next = row_eff;
            if (!emit) begin
                items_next = items_reg + 1'b1;
            end
            if (last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                items_next   = '0;
            end else if (emit) begin
                if (oc1 >= w_ext) begin
                    out_col_next = '0;
                    out_row_next = or1[CNT_W-1:0];
                end else begin
                    out_col_next = oc1[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= W_RST;
            height_reg  <= H_RST;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            items_reg   <= '0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            items_reg   <= items_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/bb3_avg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_avg
// Edge-masked 3x3 sum per channel, registered, then divide by nine through a
// reciprocal multiply and pack the RGBA word.
// ----------------------------------------------------------------------------
module bb3_avg
    import bb3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  wire ctl_t ctl,
    input  wire col_t left,
    input  wire col_t centre,
    input  wire col_t right,
    output logic      out_valid,
    output out_item_t out_item
);

    logic [SUM_W-1:0]  sum_comb [3];
    logic [SUM_W-1:0]  sum_reg  [3];
    logic [PROD_W-1:0] prod     [3];
    logic [CH_W-1:0]   quo      [3];
    logic              valid_reg;
    logic              last_reg;

    function automatic logic [SUM_W-1:0] col_sum(col_t col, int ch, logic top, logic bot);
        logic [SUM_W-1:0] s;
        s = SUM_W'(col.mid[ch*CH_W +: CH_W]);
        if (top) begin
            s = s + SUM_W'(col.top[ch*CH_W +: CH_W]);
        end
        if (bot) begin
            s = s + SUM_W'(col.bot[ch*CH_W +: CH_W]);
        end
        return s;
    endfunction

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_comb[ch] = col_sum(centre, ch, ctl.use_top, ctl.use_bot);
            if (ctl.use_left) begin
                sum_comb[ch] = sum_comb[ch] + col_sum(left, ch, ctl.use_top, ctl.use_bot);
            end
            if (ctl.use_right) begin
                sum_comb[ch] = sum_comb[ch] + col_sum(right, ch, ctl.use_top, ctl.use_bot);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            sum_reg  <= sum_comb;
            last_reg <= ctl.last;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(sum_reg[ch]) * PROD_W'(DIV_RECIP);
            quo[ch]  = prod[ch][DIV_SHIFT +: CH_W];
        end
    end

    // channel 2 is red, the top byte of the word
    assign out_item.out_pixel  = {quo[2], quo[1], quo[0], ALPHA};
    assign out_item.frame_last = last_reg;
    assign out_valid           = valid_reg;

endmodule
`default_nettype wire

@@ hdl/box_blur_3x3_rgb.sv @@
// A result passes stage 1, stage 2, the averaging register and the output
// queue; its last neighbor comes width+1 words after the pixel. Throughput:
// 1 word per cycle while the queue has room, set by one read and one write
// per line store RAM per cycle. Reset (aresetn, synchronous, active low)
// clears counters, pipeline valids and the output queue, sets both dimensions
// to 1024; line stores and window are not cleared, edge masking hides them.
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur over a raster RGB stream with two line stores, a chain of
// three window column cells, an averaging stage and an output queue.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic             accept;
    logic [AW-1:0]    rd_addr;
    logic             blank;
    ctl_t             ctl;
    logic [PIX_W-1:0] pix;

    logic             p1_valid_reg;
    ctl_t             p1_ctl_reg;
    logic [AW-1:0]    p1_addr_reg;
    logic [PIX_W-1:0] p1_pix_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_top_reg;
    logic [PIX_W-1:0] fwd_mid_reg;
    logic [PIX_W-1:0] older_rd, newer_rd;
    logic [PIX_W-1:0] top_px, mid_px;
    col_t             chain [4];

    logic             p2_valid_reg;
    ctl_t             p2_ctl_reg;

    logic             avg_valid;
    out_item_t        avg_item;

    out_item_t             fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_CNT_W-1:0] in_flight;
    logic                  pop;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    bb3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .drain     (s_data.drain),
        .addr      (rd_addr),
        .blank     (blank),
        .ctl       (ctl)
    );

    assign pix = blank ? '0 : {s_data.in_red, s_data.in_green, s_data.in_blue};

    // stage 1: line store data returns, written back at the same column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
            fwd_reg      <= accept && p1_valid_reg && (p1_addr_reg == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ctl_reg  <= ctl;
            p1_addr_reg <= rd_addr;
            p1_pix_reg  <= pix;
            fwd_top_reg <= mid_px;
            fwd_mid_reg <= p1_pix_reg;
        end
    end

    bb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_older (
        .aclk    (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_addr_reg),
        .wr_data (mid_px),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (older_rd)
    );

    bb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_newer (
        .aclk    (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_addr_reg),
        .wr_data (p1_pix_reg),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (newer_rd)
    );

    // same column on back-to-back words: take what the previous word wrote
    assign top_px = fwd_reg ? fwd_top_reg : older_rd;
    assign mid_px = fwd_reg ? fwd_mid_reg : newer_rd;

    assign chain[3] = '{top: top_px, mid: mid_px, bot: p1_pix_reg};

    for (genvar i = 0; i < 3; i++) begin : g_win
        bb3_cell u_cell (
            .aclk     (aclk),
            .shift_en (p1_valid_reg),
            .col_in   (chain[i+1]),
            .col_out  (chain[i])
        );
    end

    // stage 2: window settled, sum the neighborhood
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg && p1_ctl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            p2_ctl_reg <= p1_ctl_reg;
        end
    end

    bb3_avg u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p2_valid_reg),
        .ctl       (p2_ctl_reg),
        .left      (chain[0]),
        .centre    (chain[1]),
        .right     (chain[2]),
        .out_valid (avg_valid),
        .out_item  (avg_item)
    );

    // output queue: room is reserved for every result still in the pipeline
    assign in_flight = FIFO_CNT_W'(p1_valid_reg && p1_ctl_reg.emit)
                     + FIFO_CNT_W'(p2_valid_reg)
                     + FIFO_CNT_W'(avg_valid);
    assign s_ready   = (count_reg + in_flight) < FIFO_CNT_W'(FIFO_DEPTH);
    assign m_valid   = count_reg != '0;
    assign m_data    = fifo_mem[rd_ptr_reg];
    assign pop       = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (avg_valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!avg_valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (avg_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (avg_valid) begin
            fifo_mem[wr_ptr_reg] <= avg_item;
        end
    end

endmodule
`default_nettype wire

@@ hdl/bb3_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks on the box blur: output hold, alpha byte, source of the
// result word that fills an empty queue and input backpressure.
// ----------------------------------------------------------------------------
module bb3_checker
    import bb3_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.out_pixel[CH_W-1:0] == ALPHA)
        else $error("alpha byte not opaque");

    // an empty queue only fills from an earlier accepted input word
    a_rise_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 4))
        else $error("result word without a matching input word");

    // input stalls only when results are queued
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output queue");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);
`default_nettype wire
